FILE: hdl/event_time_priority_queue_defines.svh
// Assertion macros used by the queue datapath.
// ETPQ_ASSERT: prop must hold at every clock edge outside reset.
// ETPQ_ASSERT_NEVER: expr must never be true at a clock edge outside reset.
`ifndef EVENT_TIME_PRIORITY_QUEUE_DEFINES_SVH
`define EVENT_TIME_PRIORITY_QUEUE_DEFINES_SVH

`ifndef SYNTH
`define ETPQ_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define ETPQ_ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);
`else
`define ETPQ_ASSERT(lbl, clk, rstn, prop, msg)
`define ETPQ_ASSERT_NEVER(lbl, clk, rstn, expr, msg)
`endif

`endif

FILE: hdl/etpq_pkg.sv
`timescale 1ns / 1ps
package etpq_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 16;
  localparam int unsigned TIME_W          = 31;
  localparam int unsigned KIND_W          = 3;
  localparam int unsigned TOTAL_W         = 5;
  localparam int unsigned IN_DATA_W       = 40;
  localparam int unsigned OUT_DATA_W      = 40;
  localparam int unsigned OUT_USER_W      = 3;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_POP    = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CTRL_IDLE = 2'd0,
    CTRL_EXEC = 2'd1,
    CTRL_RESP = 2'd2
  } ctrl_state_e;

  // Controller to datapath
  typedef struct packed {
    logic    capture;
    logic    insert;
    logic    pop;
    logic    write_result;
    status_e status;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_pop;
    logic full;
    logic empty;
  } sts_t;

endpackage

FILE: hdl/etpq_ctrl.sv
`timescale 1ns / 1ps
module etpq_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  etpq_pkg::sts_t sts_i,
  output etpq_pkg::cmd_t cmd_o
);

  etpq_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= etpq_pkg::CTRL_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    cmd_o.status = etpq_pkg::STATUS_OK;
    case (state_q)
      etpq_pkg::CTRL_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = etpq_pkg::CTRL_EXEC;
        end
      end
      etpq_pkg::CTRL_EXEC: begin
        cmd_o.write_result = 1'b1;
        if (sts_i.is_pop) begin
          if (sts_i.empty) begin
            cmd_o.status = etpq_pkg::STATUS_EMPTY;
          end else begin
            cmd_o.pop = 1'b1;
          end
        end else begin
          if (sts_i.full) begin
            cmd_o.status = etpq_pkg::STATUS_FULL;
          end else begin
            cmd_o.insert = 1'b1;
          end
        end
        state_d = etpq_pkg::CTRL_RESP;
      end
      etpq_pkg::CTRL_RESP: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = etpq_pkg::CTRL_IDLE;
        end
      end
      default: begin
        state_d = etpq_pkg::CTRL_IDLE;
      end
    endcase
  end

endmodule

FILE: hdl/etpq_datapath.sv
`timescale 1ns / 1ps
`include "event_time_priority_queue_defines.svh"
module etpq_datapath #(
  parameter int unsigned QUEUE_DEPTH = etpq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  etpq_pkg::cmd_t               cmd_i,
  output etpq_pkg::sts_t               sts_o,
  input  logic                         action_i,
  input  logic [etpq_pkg::KIND_W-1:0]  event_kind_i,
  input  logic [etpq_pkg::TIME_W-1:0]  event_time_i,
  output logic [etpq_pkg::KIND_W-1:0]  popped_kind_o,
  output logic [etpq_pkg::TIME_W-1:0]  popped_time_o,
  output logic                         popped_valid_o,
  output logic [etpq_pkg::TOTAL_W-1:0] entry_total_o,
  output etpq_pkg::status_e            status_o
);

  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  logic                        action_q;
  logic [etpq_pkg::KIND_W-1:0] kind_q;
  logic [etpq_pkg::TIME_W-1:0] time_q;

  logic [etpq_pkg::TIME_W-1:0] slot_time_q [QUEUE_DEPTH];
  logic [etpq_pkg::KIND_W-1:0] slot_kind_q [QUEUE_DEPTH];
  logic [etpq_pkg::TIME_W-1:0] slot_time_d [QUEUE_DEPTH];
  logic [etpq_pkg::KIND_W-1:0] slot_kind_d [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0]      keep;

  logic [CW-1:0] count_q, count_d;
  logic [31:0]   count_ext;

  logic [etpq_pkg::KIND_W-1:0]  res_kind_q;
  logic [etpq_pkg::TIME_W-1:0]  res_time_q;
  logic                         res_valid_q;
  logic [etpq_pkg::TOTAL_W-1:0] res_total_q;
  etpq_pkg::status_e            res_status_q;

  // Operand register
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      action_q <= action_i;
      kind_q   <= event_kind_i;
      time_q   <= event_time_i;
    end
  end

  assign sts_o.is_pop = (action_q == etpq_pkg::ACT_POP);
  assign sts_o.full   = (count_q == CW'(QUEUE_DEPTH));
  assign sts_o.empty  = (count_q == '0);

  // Each cell decides whether it stays ahead of the new entry. Times are
  // kept nondecreasing, so keep is a run of ones from the head.
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic occupied;
    assign occupied = (CW'(i) < count_q);

    if (i == 0) begin : g_head
      // an equal time at the head lands right behind it
      assign keep[i] = occupied && (slot_time_q[i] <= time_q);
      always_comb begin
        slot_time_d[i] = slot_time_q[i];
        slot_kind_d[i] = slot_kind_q[i];
        if (cmd_i.insert && !keep[i]) begin
          slot_time_d[i] = time_q;
          slot_kind_d[i] = kind_q;
        end else if (cmd_i.pop) begin
          if (QUEUE_DEPTH > 1) begin
            slot_time_d[i] = slot_time_q[(i + 1) % QUEUE_DEPTH];
            slot_kind_d[i] = slot_kind_q[(i + 1) % QUEUE_DEPTH];
          end
        end
      end
    end else begin : g_body
      assign keep[i] = occupied && (slot_time_q[i] < time_q);
      always_comb begin
        slot_time_d[i] = slot_time_q[i];
        slot_kind_d[i] = slot_kind_q[i];
        if (cmd_i.insert) begin
          if (!keep[i-1]) begin
            slot_time_d[i] = slot_time_q[i-1];
            slot_kind_d[i] = slot_kind_q[i-1];
          end else if (!keep[i]) begin
            slot_time_d[i] = time_q;
            slot_kind_d[i] = kind_q;
          end
        end else if (cmd_i.pop && (i < QUEUE_DEPTH - 1)) begin
          slot_time_d[i] = slot_time_q[(i + 1) % QUEUE_DEPTH];
          slot_kind_d[i] = slot_kind_q[(i + 1) % QUEUE_DEPTH];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      slot_time_q[i] <= slot_time_d[i];
      slot_kind_q[i] <= slot_kind_d[i];
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.insert) begin
      count_d = count_q + CW'(1);
    end else if (cmd_i.pop) begin
      count_d = count_q - CW'(1);
    end
  end

  assign count_ext = 32'(count_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.write_result) begin
      res_status_q <= cmd_i.status;
      res_total_q  <= count_ext[etpq_pkg::TOTAL_W-1:0];
      res_valid_q  <= cmd_i.pop;
      if (cmd_i.pop) begin
        res_kind_q <= slot_kind_q[0];
        res_time_q <= slot_time_q[0];
      end else begin
        res_kind_q <= '0;
        res_time_q <= '0;
      end
    end
  end

  assign popped_kind_o  = res_kind_q;
  assign popped_time_o  = res_time_q;
  assign popped_valid_o = res_valid_q;
  assign entry_total_o  = res_total_q;
  assign status_o       = res_status_q;

  `ETPQ_ASSERT_NEVER(a_count_range, clk_i, rst_ni, count_q > CW'(QUEUE_DEPTH), "count overflow")
  `ETPQ_ASSERT_NEVER(a_no_insert_full, clk_i, rst_ni, cmd_i.insert && sts_o.full, "insert when full")
  `ETPQ_ASSERT_NEVER(a_no_pop_empty, clk_i, rst_ni, cmd_i.pop && sts_o.empty, "pop when empty")
  `ETPQ_ASSERT(a_insert_count, clk_i, rst_ni, cmd_i.insert |=> count_q == $past(count_q) + CW'(1), "insert count")
  `ETPQ_ASSERT(a_pop_result, clk_i, rst_ni, cmd_i.pop |=> res_valid_q && (count_q == $past(count_q) - CW'(1)), "pop result")

endmodule

FILE: hdl/event_time_priority_queue.sv
// The result is registered during the update step and offered after it, in the RESP state.
// One operation at a time: a new input transfer is taken only after the last result is taken;
// the controller runs capture, update and result hand-off in turn.
// Every cell compares its time with the new one in parallel, so the whole update is done in the EXEC state.
// Reset (async, active low) empties the queue and returns the controller to idle.
`timescale 1ns / 1ps
module event_time_priority_queue #(
  parameter int unsigned QUEUE_DEPTH = etpq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // [2:0] event_kind, [33:3] event_time, [39:34] zero
  input  logic [etpq_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  // [0] action
  input  logic [0:0]                      s_axis_tuser_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // [2:0] popped_kind, [33:3] popped_time, [38:34] entry_total, [39] zero
  output logic [etpq_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  // [0] popped_valid, [2:1] status
  output logic [etpq_pkg::OUT_USER_W-1:0] m_axis_tuser_o
);

  localparam int unsigned TIME_LO  = etpq_pkg::KIND_W;
  localparam int unsigned TIME_HI  = TIME_LO + etpq_pkg::TIME_W - 1;
  localparam int unsigned TOTAL_LO = TIME_HI + 1;
  localparam int unsigned TOTAL_HI = TOTAL_LO + etpq_pkg::TOTAL_W - 1;

  etpq_pkg::cmd_t cmd;
  etpq_pkg::sts_t sts;

  logic [etpq_pkg::KIND_W-1:0]  popped_kind;
  logic [etpq_pkg::TIME_W-1:0]  popped_time;
  logic                         popped_valid;
  logic [etpq_pkg::TOTAL_W-1:0] entry_total;
  etpq_pkg::status_e            status;

  // Sequence each operation: take the transfer, update the cells, hold the result.
  etpq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .out_valid_o(m_axis_tvalid_o),
    .out_ready_i(m_axis_tready_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Sorted row of cells, entry count and result register.
  etpq_datapath #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .action_i      (s_axis_tuser_i[0]),
    .event_kind_i  (s_axis_tdata_i[etpq_pkg::KIND_W-1:0]),
    .event_time_i  (s_axis_tdata_i[TIME_HI:TIME_LO]),
    .popped_kind_o (popped_kind),
    .popped_time_o (popped_time),
    .popped_valid_o(popped_valid),
    .entry_total_o (entry_total),
    .status_o      (status)
  );

  // Pack the result; unused high bits stay zero.
  always_comb begin
    m_axis_tdata_o                           = '0;
    m_axis_tdata_o[etpq_pkg::KIND_W-1:0]     = popped_kind;
    m_axis_tdata_o[TIME_HI:TIME_LO]          = popped_time;
    m_axis_tdata_o[TOTAL_HI:TOTAL_LO]        = entry_total;
    m_axis_tuser_o                           = {status, popped_valid};
  end

endmodule

FILE: tb/event_time_priority_queue_tb.sv
`timescale 1ns / 1ps
module event_time_priority_queue_tb;
  import etpq_pkg::*;

  localparam int unsigned DEPTH      = QUEUE_DEPTH_DEF;
  localparam int unsigned STALL_MAX  = 3000;  // cycles without any transfer
  localparam int unsigned RAND_OPS   = 450;
  localparam int unsigned HOLD_LEN   = 200;   // long receiver hold-off
  localparam logic [TIME_W-1:0] T_MAX = {TIME_W{1'b1}};

  // One result item as the block reports it
  typedef struct {
    logic [KIND_W-1:0]  kind;
    logic [TIME_W-1:0]  stamp;
    logic               valid;
    logic [TOTAL_W-1:0] total;
    status_e            status;
  } queue_result_t;

  // Mirror of the sorted queue plus the results still owed by the block
  class event_queue_mirror;
    logic [TIME_W-1:0] slot_time [DEPTH];
    logic [KIND_W-1:0] slot_kind [DEPTH];
    int unsigned       stored;
    queue_result_t     due_results [$];
    int unsigned       errors;

    function new();
      stored = 0;
      errors = 0;
    endfunction

    // Apply one accepted operation and queue the result it must produce
    function void note_request(logic act, logic [KIND_W-1:0] kind,
                               logic [TIME_W-1:0] stamp);
      queue_result_t r;
      int unsigned   pos;
      r.kind   = '0;
      r.stamp  = '0;
      r.valid  = 1'b0;
      r.status = STATUS_OK;
      if (act == ACT_INSERT) begin
        if (stored >= DEPTH) begin
          r.status = STATUS_FULL;
        end else begin
          pos = 0;
          for (int i = 0; i < stored; i++)
            if (slot_time[i] < stamp) pos++;
          // a tie with the head lands right behind it
          if (pos == 0 && stored > 0 && slot_time[0] == stamp) pos = 1;
          for (int i = stored; i > pos; i--) begin
            slot_time[i] = slot_time[i-1];
            slot_kind[i] = slot_kind[i-1];
          end
          slot_time[pos] = stamp;
          slot_kind[pos] = kind;
          stored++;
        end
      end else begin
        if (stored == 0) begin
          r.status = STATUS_EMPTY;
        end else begin
          r.kind  = slot_kind[0];
          r.stamp = slot_time[0];
          r.valid = 1'b1;
          for (int i = 1; i < stored; i++) begin
            slot_time[i-1] = slot_time[i];
            slot_kind[i-1] = slot_kind[i];
          end
          stored--;
        end
      end
      r.total = stored[TOTAL_W-1:0];
      due_results.push_back(r);
    endfunction

    function void flag(string field, longint unsigned want, longint unsigned got);
      $display("%0t: mismatch in %s, expected %0d, actual %0d", $time, field, want, got);
      errors++;
    endfunction

    // Compare one result transfer against the oldest owed result
    function void check_result(logic [OUT_DATA_W-1:0] data, logic [OUT_USER_W-1:0] user);
      queue_result_t want;
      if (due_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual data %h user %h",
                 $time, data, user);
        errors++;
        return;
      end
      want = due_results.pop_front();
      if (data[2:0] !== want.kind)    flag("popped_kind", want.kind, data[2:0]);
      if (data[33:3] !== want.stamp)  flag("popped_time", want.stamp, data[33:3]);
      if (data[38:34] !== want.total) flag("entry_total", want.total, data[38:34]);
      if (user[0] !== want.valid)     flag("popped_valid", want.valid, user[0]);
      if (user[2:1] !== want.status)  flag("status", want.status, user[2:1]);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata  = '0;
  logic [0:0]            s_tuser  = ACT_INSERT;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [OUT_USER_W-1:0] m_tuser;

  // Shared pacing controls, written with nonblocking assignments at the edge
  logic calm         = 1'b0;  // no idling on either side while set
  logic holdoff_req  = 1'b0;  // ask the receiver for one long hold-off

  event_queue_mirror mirror;

  always #5 clk = ~clk;

  event_time_priority_queue DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),   // [2:0] event_kind, [33:3] event_time, [39:34] zero
    .s_axis_tuser_i  (s_tuser),   // [0] action
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),   // [2:0] kind, [33:3] time, [38:34] entry_total, [39] zero
    .m_axis_tuser_o  (m_tuser)    // [0] popped_valid, [2:1] status
  );

  // Offer one operation and hold it until the block takes the transfer.
  // Returns in the time step of the accepting edge.
  task automatic send_op(logic act, logic [KIND_W-1:0] kind, logic [TIME_W-1:0] stamp);
    if (!calm && $urandom_range(0, 99) < 18) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {6'b0, stamp, kind};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    mirror.note_request(act, kind, stamp);
  endtask

  // Pick a timestamp: narrow range for ties, extremes, or anything
  function automatic logic [TIME_W-1:0] pick_stamp();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) return TIME_W'($urandom_range(0, 7));
    if (roll < 45) return '0;
    if (roll < 50) return T_MAX - TIME_W'($urandom_range(0, 1));
    return TIME_W'($urandom);
  endfunction

  // Receiver: check each result transfer, then pick the next ready level
  initial begin : receiver
    int unsigned hold_left;
    logic        hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && m_tvalid && m_tready) mirror.check_result(m_tdata, m_tuser);
      if (holdoff_req && !hold_done) begin
        hold_left = HOLD_LEN;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (calm) begin
        m_tready <= 1'b1;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= 18);
      end
    end
  end

  // Watchdog: end the run when no transfer happens for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n) quiet = 0;
      else quiet++;
      if (quiet >= STALL_MAX) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int unsigned ins_pct;
    mirror = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty pop, ties with the head, ties further back, extremes
    send_op(ACT_POP, '0, '0);
    send_op(ACT_INSERT, 3'd1, 31'd100);
    send_op(ACT_INSERT, 3'd2, 31'd100);   // equal to head, goes second
    send_op(ACT_INSERT, 3'd0, '0);        // new minimum
    send_op(ACT_INSERT, 3'd7, T_MAX);     // largest time
    send_op(ACT_INSERT, 3'd3, '0);        // equal to head again
    send_op(ACT_INSERT, 3'd4, 31'd100);   // equal to middle entries, goes ahead
    send_op(ACT_INSERT, 3'd5, 31'd50);
    send_op(ACT_INSERT, 3'd6, T_MAX);
    repeat (9) send_op(ACT_POP, 3'd7, T_MAX);  // drain, ignored fields all ones
    send_op(ACT_POP, 3'd5, 31'h2AAA_AAAA);     // empty again
    send_op(ACT_INSERT, 3'd7, T_MAX);
    send_op(ACT_POP, '0, '0);

    // Random: segments that lean toward fill, balance or drain
    ins_pct = 90;
    for (int i = 0; i < RAND_OPS; i++) begin
      if (i % 30 == 0 && i != 0) begin
        case ($urandom_range(0, 2))
          0: ins_pct = 90;
          1: ins_pct = 50;
          default: ins_pct = 15;
        endcase
      end
      if (i == 60) holdoff_req <= 1'b1;
      if (i == 200) calm <= 1'b1;
      if (i == 300) calm <= 1'b0;
      if ($urandom_range(0, 99) < ins_pct)
        send_op(ACT_INSERT, KIND_W'($urandom_range(0, 7)), pick_stamp());
      else
        send_op(ACT_POP, KIND_W'($urandom_range(0, 7)), TIME_W'($urandom));
    end
    s_tvalid <= 1'b0;

    // Drain owed results, then give stray results a chance to show up
    while (mirror.due_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mirror.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
